FILE: design/hargtok_pkg.sv
// Shared types and constants for the header argument list tokenizer.
// Used by every module of the block but hargtok_ram; no dependencies.
`default_nettype none

package hargtok_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // result kinds
  localparam logic [1:0] KIND_FIRST = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  localparam int unsigned CMDQ_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_NAME_LEAD,
    PH_NAME,
    PH_VAL_LEAD,
    PH_VAL,
    PH_QUOTED,
    PH_AFTER_QUOTE
  } ph_t;

  typedef enum logic [1:0] {
    OP_BLANK,   // hold one blank back
    OP_DROP,    // discard held blanks
    OP_CHAR,    // release held blanks, then the byte
    OP_MARK     // end-of-pair or empty-list marker
  } op_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       terminator;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  out_kind;
    logic [15:0] pair_index;
    logic        pair_named;
    logic        list_last;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic        pre_mark;  // close the previous pair before the byte
    logic [7:0]  ch;
    logic [1:0]  kind;
    logic [15:0] index;     // index of the marker when pre_mark is set
    logic        named;
    logic        last;
  } cmd_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

`default_nettype wire

FILE: design/hargtok_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hargtok_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/hargtok_cmd_fifo.sv
// Short command queue between the parser front end and the output back end.
// Depends on hargtok_pkg.
`default_nettype none

module hargtok_cmd_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire hargtok_pkg::cmd_t  push_cmd,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output hargtok_pkg::cmd_t       head
);
  import hargtok_pkg::*;

  localparam int PW = $clog2(CMDQ_DEPTH);

  cmd_t          slots [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;

  assign full       = (fill == (PW+1)'(CMDQ_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/hargtok_front.sv
// Parser front end: takes one request byte a cycle while accept is high,
// tracks item phase and count, issues at most one back-end command a byte.
// Depends on hargtok_pkg.
`default_nettype none

module hargtok_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire hargtok_pkg::in_item_t item,
  output logic                       push,
  output hargtok_pkg::cmd_t          cmd
);
  import hargtok_pkg::*;

  ph_t         phase;
  ph_t         phase_next;
  logic [15:0] item_counter;
  logic [15:0] item_counter_next;
  logic        seen_equals;
  logic        seen_equals_next;

  logic [7:0]  c;
  logic        is_end;
  logic        is_blank;
  logic [15:0] opened;
  logic [15:0] idx;
  logic        emit;

  assign c        = item.in_byte;
  assign is_end   = item.terminator || (c == CH_NUL);
  assign is_blank = (c == CH_SPACE) || (c == CH_TAB);
  assign opened   = sat_inc(item_counter);
  assign push     = accept && emit;

  always_comb begin
    phase_next        = phase;
    item_counter_next = item_counter;
    seen_equals_next  = seen_equals;
    emit              = 1'b0;
    idx               = (phase == PH_IDLE) ? opened : item_counter;
    cmd.op            = OP_DROP;
    cmd.pre_mark      = 1'b0;
    cmd.ch            = c;
    cmd.kind          = KIND_FIRST;
    cmd.index         = item_counter;
    cmd.named         = 1'b0;
    cmd.last          = 1'b0;

    if (is_end) begin
      emit              = 1'b1;
      cmd.op            = OP_MARK;
      cmd.ch            = CH_NUL;
      cmd.kind          = (phase == PH_IDLE) ? KIND_EMPTY : KIND_END;
      cmd.named         = (phase == PH_IDLE) ? 1'b0 : seen_equals;
      cmd.last          = 1'b1;
      phase_next        = PH_IDLE;
      item_counter_next = '0;
      seen_equals_next  = 1'b0;
    end else begin
      unique case (phase)
        PH_IDLE, PH_NAME_LEAD, PH_NAME: begin
          item_counter_next = idx;
          cmd.index         = idx;
          priority if (c == CH_COMMA) begin
            emit             = 1'b1;
            cmd.op           = OP_MARK;
            cmd.ch           = CH_NUL;
            cmd.kind         = KIND_END;
            cmd.named        = seen_equals;
            phase_next       = PH_IDLE;
            seen_equals_next = 1'b0;
          end else if (c == CH_EQ) begin
            emit             = (phase == PH_NAME);
            cmd.op           = OP_DROP;
            seen_equals_next = 1'b1;
            phase_next       = PH_VAL_LEAD;
          end else if (is_blank) begin
            emit   = (phase == PH_NAME);
            cmd.op = OP_BLANK;
            if (phase == PH_IDLE) begin
              phase_next = PH_NAME_LEAD;
            end
          end else begin
            emit       = 1'b1;
            cmd.op     = OP_CHAR;
            cmd.kind   = KIND_FIRST;
            phase_next = PH_NAME;
          end
        end
        PH_VAL_LEAD, PH_VAL: begin
          priority if (c == CH_COMMA) begin
            emit             = 1'b1;
            cmd.op           = OP_MARK;
            cmd.ch           = CH_NUL;
            cmd.kind         = KIND_END;
            cmd.named        = seen_equals;
            phase_next       = PH_IDLE;
            seen_equals_next = 1'b0;
          end else if (is_blank) begin
            emit   = (phase == PH_VAL);
            cmd.op = OP_BLANK;
          end else if ((c == CH_QUOTE) && (phase == PH_VAL_LEAD)) begin
            phase_next = PH_QUOTED;
          end else begin
            emit       = 1'b1;
            cmd.op     = OP_CHAR;
            cmd.kind   = KIND_VALUE;
            phase_next = PH_VAL;
          end
        end
        PH_QUOTED: begin
          if (c == CH_QUOTE) begin
            phase_next = PH_AFTER_QUOTE;
          end else begin
            emit     = 1'b1;
            cmd.op   = OP_CHAR;
            cmd.kind = KIND_VALUE;
          end
        end
        PH_AFTER_QUOTE: begin
          // anything but a blank closes the quoted pair
          priority if (is_blank) begin
            emit = 1'b0;
          end else if (c == CH_COMMA) begin
            emit             = 1'b1;
            cmd.op           = OP_MARK;
            cmd.ch           = CH_NUL;
            cmd.kind         = KIND_END;
            cmd.named        = seen_equals;
            phase_next       = PH_IDLE;
            seen_equals_next = 1'b0;
          end else if (c == CH_EQ) begin
            emit              = 1'b1;
            cmd.op            = OP_MARK;
            cmd.ch            = CH_NUL;
            cmd.kind          = KIND_END;
            cmd.named         = seen_equals;
            item_counter_next = opened;
            seen_equals_next  = 1'b1;
            phase_next        = PH_VAL_LEAD;
          end else begin
            emit              = 1'b1;
            cmd.op            = OP_CHAR;
            cmd.pre_mark      = 1'b1;
            cmd.kind          = KIND_FIRST;
            cmd.named         = seen_equals;
            item_counter_next = opened;
            seen_equals_next  = 1'b0;
            phase_next        = PH_NAME;
          end
        end
        default: begin
          phase_next        = PH_IDLE;
          item_counter_next = '0;
          seen_equals_next  = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      item_counter <= '0;
      seen_equals  <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      item_counter <= item_counter_next;
      seen_equals  <= seen_equals_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/hargtok_back.sv
// Output back end: executes queued commands, keeps held-back blanks in a
// small RAM and feeds the output register. Depends on hargtok_pkg, hargtok_ram.
`default_nettype none

module hargtok_back #(
  parameter int WS_DEPTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  input  wire hargtok_pkg::cmd_t    cmd,
  output logic                      cmd_pop,
  output logic                      tok_valid,
  input  wire logic                 tok_ready,
  output hargtok_pkg::out_item_t    tok_item
);
  import hargtok_pkg::*;

  localparam int CW = $clog2(WS_DEPTH + 1);
  localparam int AW = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;

  typedef struct packed {
    out_item_t item;
    logic      from_ram;
  } slot_t;

  logic [CW-1:0] blank_count;
  logic [CW-1:0] blank_count_next;
  logic [CW-1:0] ptr;
  logic [CW-1:0] ptr_next;
  logic          pre_done;
  logic          pre_done_next;
  logic          out_valid;
  slot_t         meta;

  slot_t         slot;
  logic          slot_valid;
  logic          advance;
  logic          ram_we;
  logic          ram_re;
  logic [0:0]    ram_rdata;
  logic [15:0]   char_index;

  assign advance    = !out_valid || tok_ready;
  assign char_index = cmd.pre_mark ? sat_inc(cmd.index) : cmd.index;

  hargtok_ram #(
    .WIDTH (1),
    .DEPTH (WS_DEPTH)
  ) u_blank_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (blank_count[AW-1:0]),
    .wdata (cmd.ch == CH_TAB),
    .re    (ram_re),
    .raddr (ptr[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    blank_count_next = blank_count;
    ptr_next         = ptr;
    pre_done_next    = pre_done;
    cmd_pop          = 1'b0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    slot_valid       = 1'b0;
    slot.from_ram         = 1'b0;
    slot.item.out_byte    = cmd.ch;
    slot.item.out_kind    = cmd.kind;
    slot.item.pair_index  = cmd.index;
    slot.item.pair_named  = 1'b0;
    slot.item.list_last   = 1'b0;

    if (cmd_valid) begin
      unique case (cmd.op)
        OP_BLANK: begin
          cmd_pop = 1'b1;
          // excess blanks past the store depth are dropped
          if (blank_count < CW'(WS_DEPTH)) begin
            ram_we           = 1'b1;
            blank_count_next = blank_count + 1'b1;
          end
        end
        OP_DROP: begin
          cmd_pop          = 1'b1;
          blank_count_next = '0;
        end
        OP_MARK: begin
          slot_valid           = 1'b1;
          slot.item.out_byte   = CH_NUL;
          slot.item.pair_named = cmd.named;
          slot.item.list_last  = cmd.last;
          if (advance) begin
            cmd_pop          = 1'b1;
            blank_count_next = '0;
            ptr_next         = '0;
          end
        end
        OP_CHAR: begin
          slot_valid = 1'b1;
          if (cmd.pre_mark && !pre_done) begin
            slot.item.out_byte   = CH_NUL;
            slot.item.out_kind   = KIND_END;
            slot.item.pair_named = cmd.named;
            if (advance) begin
              pre_done_next = 1'b1;
            end
          end else if (ptr < blank_count) begin
            slot.from_ram        = 1'b1;
            slot.item.pair_index = char_index;
            ram_re               = advance;
            if (advance) begin
              ptr_next = ptr + 1'b1;
            end
          end else begin
            slot.item.pair_index = char_index;
            if (advance) begin
              cmd_pop          = 1'b1;
              blank_count_next = '0;
              ptr_next         = '0;
              pre_done_next    = 1'b0;
            end
          end
        end
        default: begin
          cmd_pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_count <= '0;
      ptr         <= '0;
      pre_done    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      blank_count <= blank_count_next;
      ptr         <= ptr_next;
      pre_done    <= pre_done_next;
      if (advance) begin
        out_valid <= slot_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && slot_valid) begin
      meta <= slot;
    end
  end

  // blank bytes come straight from the registered RAM read
  always_comb begin
    tok_item = meta.item;
    if (meta.from_ram) begin
      tok_item.out_byte = ram_rdata[0] ? CH_TAB : CH_SPACE;
    end
  end

  assign tok_valid = out_valid;

endmodule

`default_nettype wire

FILE: design/header_arg_list_tokenizer_unit.sv
// Top level of the header argument list tokenizer.
// Depends on hargtok_pkg, hargtok_front, hargtok_cmd_fifo, hargtok_back.
`default_nettype none

// Splits a comma-separated header argument list (value, name=value,
// name="value") into tagged bytes: first-part bytes, value bytes, an
// end-of-pair marker per item with its index and named flag, and a single
// empty-list marker where no pair is open at the end. A terminator request
// or a zero byte ends the list and returns the block to its reset state.
// The front end takes one request byte per cycle while its four-entry
// command queue has room. The back end issues at most one result per
// cycle into the output register while tok_ready does not stall it: a
// byte that follows k held-back blanks comes after those k blanks (k at
// most WS_DEPTH, read one per cycle from the blank RAM), and a byte that
// directly follows a closing quote comes after the marker of the quoted
// pair. Blanks and '=' in a name produce no result.
module header_arg_list_tokenizer_unit #(
  parameter int WS_DEPTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   char_valid,
  output logic                        char_ready,
  input  wire hargtok_pkg::in_item_t  char_item,
  output logic                        tok_valid,
  input  wire logic                   tok_ready,
  output hargtok_pkg::out_item_t      tok_item
);
  import hargtok_pkg::*;

  logic char_accept;
  logic cmd_push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_head;

  assign char_ready  = !q_full;
  assign char_accept = char_valid && char_ready;

  hargtok_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (char_accept),
    .item   (char_item),
    .push   (cmd_push),
    .cmd    (push_cmd)
  );

  hargtok_cmd_fifo u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  hargtok_back #(
    .WS_DEPTH (WS_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_item  (tok_item)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("command popped from an empty queue");

  a_marker_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && (tok_item.out_kind == KIND_END || tok_item.out_kind == KIND_EMPTY))
      |-> (tok_item.out_byte == CH_NUL))
    else $error("marker result carries a non-zero byte");

  a_flags_only_on_markers: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && (tok_item.pair_named || tok_item.list_last))
      |-> (tok_item.out_kind == KIND_END || tok_item.out_kind == KIND_EMPTY))
    else $error("named or last flag set on a byte result");

endmodule

`default_nettype wire
